// ----- rtl/spq_pkg.sv -----
package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int TAG_BITS      = 8;
  localparam int PRIO_BITS     = 8;
  localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int KIND_BITS     = 2;
  localparam int STATUS_BITS   = 2;

  typedef logic [TAG_BITS-1:0]   tag_t;
  typedef logic [PRIO_BITS-1:0]  prio_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_DELETE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  // what the top asks of every cell in each cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_t;

  typedef struct packed {
    tag_t  tag;
    prio_t prio;
  } entry_t;

  // signals rippling from the head toward the tail of the chain
  typedef struct packed {
    logic   keep;  // this cell stays put on insert
    logic   hit;   // a tag match was seen at or before this cell
    entry_t found; // entry of the first tag match, zero if none yet
  } link_t;

endpackage

// ----- rtl/spq_if.sv -----
interface spq_in_if;
  logic                           valid;
  logic                           ready;
  logic [spq_pkg::KIND_BITS-1:0]  kind;
  logic [spq_pkg::TAG_BITS-1:0]   entry_tag;
  logic [spq_pkg::PRIO_BITS-1:0]  new_priority;

  modport source (output valid, kind, entry_tag, new_priority, input ready);
  modport sink   (input valid, kind, entry_tag, new_priority, output ready);
endinterface

interface spq_out_if;
  logic                            valid;
  logic                            ready;
  logic [spq_pkg::STATUS_BITS-1:0] status;
  logic [spq_pkg::TAG_BITS-1:0]    result_tag;
  logic [spq_pkg::PRIO_BITS-1:0]   result_priority;
  logic [spq_pkg::COUNT_BITS-1:0]  queue_count;

  modport source (output valid, status, result_tag, result_priority, queue_count,
                  input ready);
  modport sink   (input valid, status, result_tag, result_priority, queue_count,
                  output ready);
endinterface

// ----- rtl/spq_cell.sv -----
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_op_t op,
  input  logic              valid,
  input  spq_pkg::entry_t   new_entry,
  input  spq_pkg::tag_t     del_tag,
  input  spq_pkg::entry_t   left_entry,
  input  spq_pkg::entry_t   right_entry,
  input  spq_pkg::link_t    link_in,
  output spq_pkg::link_t    link_out,
  output spq_pkg::entry_t   entry
);

  logic match;
  logic keep;

  assign match = valid && (entry.tag == del_tag);
  assign keep  = valid && (entry.prio <= new_entry.prio);

  always_comb begin
    link_out.keep  = keep;
    link_out.hit   = link_in.hit || match;
    link_out.found = (!link_in.hit && match) ? entry : link_in.found;
  end

  always_ff @(posedge clk) begin
    case (op)
      spq_pkg::CELL_INSERT: begin
        if (!keep) begin
          entry <= link_in.keep ? new_entry : left_entry;
        end
      end
      spq_pkg::CELL_POP: begin
        entry <= right_entry;
      end
      spq_pkg::CELL_DELETE: begin
        if (link_in.hit || match) begin
          entry <= right_entry;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// sorted priority queue: holds up to spq_pkg::QUEUE_DEPTH tagged entries in a
// row of cells kept in order, head at cell 0, lower priority value first and
// equal priorities in arrival order. each request item is an insert, a pop of
// the head or a delete of the first entry with a given tag, and gives exactly
// one result item (status, tag, priority, count after the item). one item is
// taken per clock: every cell compares against the request in parallel and
// shifts toward its neighbor in the same cycle, so the result is in the output
// register in the cycle after acceptance. the rate is set by the tag-match ripple
// along the chain, which finishes within the accepting cycle. req.ready drops
// only while a finished result sits unclaimed in the output register.
module sorted_priority_queue (
  input logic       clk,
  input logic       rst,
  spq_in_if.sink    req,
  spq_out_if.source rsp
);

  localparam int N = spq_pkg::QUEUE_DEPTH;

  localparam int COUNT_W_EXT = spq_pkg::COUNT_BITS + 1 > $clog2(N) + 1 ?
                               spq_pkg::COUNT_BITS + 1 : $clog2(N) + 1;

  spq_pkg::count_t   count;
  spq_pkg::count_t   count_next;
  spq_pkg::cell_op_t cell_op;
  spq_pkg::entry_t   new_entry;
  spq_pkg::entry_t   cell_entry [N];
  spq_pkg::link_t    link [N+1];
  logic [N-1:0]      cell_valid;

  logic            fire;
  logic            full;
  logic            empty;
  spq_pkg::status_t status_next;
  spq_pkg::entry_t  result_next;

  assign fire       = req.valid && req.ready;
  // output register frees up when the sink takes the held result
  assign req.ready  = !rsp.valid || rsp.ready;
  assign full       = (count == spq_pkg::count_t'(N));
  assign empty      = (count == '0);
  assign new_entry  = '{tag: req.entry_tag, prio: req.new_priority};

  // occupancy of each cell follows from the fill count
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_valid[i] = (COUNT_W_EXT'(i) < COUNT_W_EXT'(count));
    end
  end

  // head of the chain: everything before cell 0 counts as kept, no match yet
  assign link[0] = '{keep: 1'b1, hit: 1'b0, found: '0};

  // decode the request into one command for the whole row
  always_comb begin
    cell_op     = spq_pkg::CELL_HOLD;
    status_next = spq_pkg::STATUS_MISSING;
    result_next = '0;
    count_next  = count;
    unique case (req.kind)
      spq_pkg::KIND_INSERT: begin
        if (full) begin
          status_next = spq_pkg::STATUS_FULL;
        end else begin
          cell_op     = spq_pkg::CELL_INSERT;
          status_next = spq_pkg::STATUS_OK;
          result_next = new_entry;
          count_next  = count + spq_pkg::count_t'(1);
        end
      end
      spq_pkg::KIND_POP: begin
        if (!empty) begin
          cell_op     = spq_pkg::CELL_POP;
          status_next = spq_pkg::STATUS_OK;
          result_next = cell_entry[0];
          count_next  = count - spq_pkg::count_t'(1);
        end
      end
      spq_pkg::KIND_DELETE: begin
        // cells shift on their own from the first match on, nothing moves on a miss
        cell_op = spq_pkg::CELL_DELETE;
        if (link[N].hit) begin
          status_next = spq_pkg::STATUS_OK;
          result_next = link[N].found;
          count_next  = count - spq_pkg::count_t'(1);
        end
      end
      default: begin
        // unused kind: no-op, reported as missing
        cell_op = spq_pkg::CELL_HOLD;
      end
    endcase
    if (!fire) begin
      cell_op    = spq_pkg::CELL_HOLD;
      count_next = count;
    end
  end

  // the row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
    end

    if (i == N - 1) begin : g_tail
      // tail cell becomes unoccupied when the row moves up
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .op          (cell_op),
      .valid       (cell_valid[i]),
      .new_entry   (new_entry),
      .del_tag     (req.entry_tag),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .link_in     (link[i]),
      .link_out    (link[i+1]),
      .entry       (cell_entry[i])
    );
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status          <= status_next;
      rsp.result_tag      <= result_next.tag;
      rsp.result_priority <= result_next.prio;
      rsp.queue_count     <= count_next;
    end
  end

endmodule
